@@ design/dcae_pkg.sv @@
// ----------------------------------------------------------------------------
// dcae_pkg
// Types and codes shared by the dual-core arithmetic execute unit.
// ----------------------------------------------------------------------------
package dcae_pkg;

  // request kinds
  localparam logic [2:0] REQ_ARITH = 3'd0;
  localparam logic [2:0] REQ_WR_D  = 3'd1;
  localparam logic [2:0] REQ_WR_A  = 3'd2;
  localparam logic [2:0] REQ_WR_M  = 3'd3;
  localparam logic [2:0] REQ_READ  = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_ADDR = 2'd2;

  localparam int REGS_PER_CORE = 4;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } alu_op_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DEC,
    S_DRD,
    S_SRC,
    S_SRD,
    S_EXEC,
    S_WAIT,
    S_RRD,
    S_OUT
  } state_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic div0;
  } alu_rsp_t;

endpackage

@@ design/dcae_ram.sv @@
// ----------------------------------------------------------------------------
// dcae_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dcae_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

@@ design/dcae_alu.sv @@
// ----------------------------------------------------------------------------
// dcae_alu
// Shared arithmetic unit: registered add, subtract and multiply, and a
// radix-2 restoring signed divider that takes sixteen steps.
// ----------------------------------------------------------------------------
module dcae_alu (
  input  logic                clk,
  input  logic                rst_n,
  input  dcae_pkg::alu_req_t  req,
  input  logic [15:0]         a,
  input  logic [15:0]         b,
  output dcae_pkg::alu_rsp_t  rsp,
  output logic [15:0]         result
);
  import dcae_pkg::*;

  logic        div_busy_r;
  logic [3:0]  cnt_r;
  logic [15:0] rem_r;
  logic [15:0] quo_r;
  logic [15:0] den_r;
  logic        neg_r;
  logic        done_r;
  logic        div0_r;
  logic [15:0] result_r;

  logic [31:0] prod;
  logic [15:0] a_mag;
  logic [15:0] b_mag;
  logic [16:0] shifted;
  logic [16:0] trial;
  logic [15:0] rem_step;
  logic [15:0] quo_step;

  assign prod  = a * b;
  assign a_mag = a[15] ? (16'd0 - a) : a;
  assign b_mag = b[15] ? (16'd0 - b) : b;

  // one restoring step: shift in the next dividend bit, try the subtract
  assign shifted  = {rem_r, quo_r[15]};
  assign trial    = shifted - {1'b0, den_r};
  assign rem_step = trial[16] ? shifted[15:0] : trial[15:0];
  assign quo_step = {quo_r[14:0], ~trial[16]};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
      done_r     <= 1'b0;
      div0_r     <= 1'b0;
      cnt_r      <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        div0_r <= 1'b0;
        if (req.op == OP_DIV) begin
          if (b == 16'd0) begin
            done_r <= 1'b1;
            div0_r <= 1'b1;
          end else begin
            div_busy_r <= 1'b1;
            cnt_r      <= '0;
          end
        end else begin
          done_r <= 1'b1;
        end
      end else if (div_busy_r) begin
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          div_busy_r <= 1'b0;
          done_r     <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= a_mag;
      den_r <= b_mag;
      neg_r <= a[15] ^ b[15];
      case (req.op)
        OP_ADD:  result_r <= a + b;
        OP_SUB:  result_r <= a - b;
        OP_MUL:  result_r <= prod[15:0];
        default: result_r <= '0;
      endcase
    end else if (div_busy_r) begin
      rem_r <= rem_step;
      quo_r <= quo_step;
      if (cnt_r == 4'd15) begin
        result_r <= neg_r ? (16'd0 - quo_step) : quo_step;
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.div0 = div0_r;
  assign result   = result_r;

endmodule

@@ design/dual_core_arith_execute_unit.sv @@
// ----------------------------------------------------------------------------
// dual_core_arith_execute_unit
// Register/memory arithmetic execute stage shared by two cores.
//
//   channel  | ports                                  | handshake
//   ---------+----------------------------------------+---------------------
//   request  | in_req_type .. in_addr_value           | start && !busy
//   result   | out_result_value, out_status, out_wm.. | out_valid, 1 cycle
//
// Register writes and reads go from decode straight to the result strobe,
// memory reads through a RAM read state. Arithmetic runs decode, a RAM
// read of a memory destination, the source fetch, a RAM read of a memory
// source, the ALU start and the ALU wait, which for a divide with a
// nonzero divisor spans the 16-step shared divider. After reset the data
// memory is cleared, one word a cycle, while busy is high. The receiver
// cannot stall: each result is shown for one cycle, then the unit returns to idle.
// ----------------------------------------------------------------------------
module dual_core_arith_execute_unit #(
  parameter int NUM_CORES  = 2,
  parameter int DATA_WORDS = 256,
  parameter int DATA_BASE  = 16384
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_req_type,
  input  logic               in_core,
  input  logic [3:0]         in_dest_reg,
  input  logic [3:0]         in_src_reg,
  input  logic signed [15:0] in_immediate,
  input  logic [1:0]         in_alu_op,
  input  logic [15:0]        in_addr_value,
  output logic               out_valid,
  output logic signed [15:0] out_result_value,
  output logic [1:0]         out_status,
  output logic               out_wrote_memory
);
  import dcae_pkg::*;

  localparam int NREGS  = NUM_CORES * REGS_PER_CORE;
  localparam int RIDX_W = $clog2(NREGS);
  localparam int IDX_W  = $clog2(DATA_WORDS);

  state_t state_r, state_nxt;

  // captured item
  logic [2:0]  req_r;
  logic        core_r;
  logic [3:0]  dst_r;
  logic [3:0]  src_r;
  logic [15:0] imm_r;
  logic [1:0]  op_r;
  logic [15:0] addr_r;

  // operands and result
  logic [15:0]      a_r, a_nxt;
  logic [15:0]      b_r, b_nxt;
  logic [IDX_W-1:0] didx_r, didx_nxt;
  logic [15:0]      val_r, val_nxt;
  logic [1:0]       st_r, st_nxt;
  logic             wm_r, wm_nxt;
  logic [IDX_W-1:0] clr_r;

  // register files
  logic [15:0] dreg_r [NREGS];
  logic [15:0] areg_r [NREGS];

  logic              core_idx;
  logic [3:0]        cur_code;
  logic [1:0]        code_low;
  logic [RIDX_W-1:0] ridx;
  logic [15:0]       dreg_rd;
  logic [15:0]       areg_rd;
  logic              dwe, awe;
  logic [15:0]       dwdata;

  logic             dst_d, dst_a, src_0, src_d, src_a, codes_ok;
  logic [15:0]      chk_addr;
  logic [16:0]      diff;
  logic             addr_ok;
  logic [IDX_W-1:0] chk_idx;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [15:0]      ram_wdata;
  logic [15:0]      ram_rdata;

  alu_req_t    alu_req;
  alu_rsp_t    alu_rsp;
  logic [15:0] alu_res;

  logic accept;

  assign accept = start && !busy;

  // register code decode
  assign dst_d    = dst_r inside {[4'd1:4'd4]};
  assign dst_a    = dst_r inside {[4'd5:4'd8]};
  assign src_0    = (src_r == 4'd0);
  assign src_d    = src_r inside {[4'd1:4'd4]};
  assign src_a    = src_r inside {[4'd5:4'd8]};
  assign codes_ok = (dst_d || dst_a) && (src_0 || src_d || src_a);

  // one register read port; codes 1-4 and 5-8 share the low-bit mapping
  assign core_idx = (NUM_CORES > 1) ? core_r : 1'b0;
  assign cur_code = (state_r == S_SRC) ? src_r : dst_r;
  assign code_low = cur_code[1:0] - 2'd1;
  assign ridx     = RIDX_W'({core_idx, code_low});
  assign dreg_rd  = dreg_r[ridx];
  assign areg_rd  = areg_r[ridx];

  // data segment check and word index
  assign chk_addr = ((state_r == S_SRC) || (req_r == REQ_ARITH)) ? areg_rd : addr_r;
  assign diff     = {1'b0, chk_addr} - 17'(DATA_BASE);
  assign addr_ok  = !diff[16] && ({1'b0, diff[15:1]} < 16'(DATA_WORDS));
  assign chk_idx  = diff[IDX_W:1];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_r == IDX_W'(DATA_WORDS - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (start) state_nxt = S_DEC;
      S_DEC: begin
        case (req_r)
          REQ_ARITH: begin
            if (!codes_ok) state_nxt = S_OUT;
            else if (dst_d) state_nxt = S_SRC;
            else if (addr_ok) state_nxt = S_DRD;
            else state_nxt = S_OUT;
          end
          REQ_READ: begin
            if (!dst_d && !dst_a && addr_ok) state_nxt = S_RRD;
            else state_nxt = S_OUT;
          end
          default: state_nxt = S_OUT;
        endcase
      end
      S_DRD: state_nxt = S_SRC;
      S_SRC: begin
        if (src_a) state_nxt = addr_ok ? S_SRD : S_OUT;
        else state_nxt = S_EXEC;
      end
      S_SRD:  state_nxt = S_EXEC;
      S_EXEC: state_nxt = S_WAIT;
      S_WAIT: if (alu_rsp.done) state_nxt = S_OUT;
      S_RRD:  state_nxt = S_OUT;
      S_OUT:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath controls per state
  always_comb begin
    val_nxt       = val_r;
    st_nxt        = st_r;
    wm_nxt        = wm_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    didx_nxt      = didx_r;
    dwe           = 1'b0;
    awe           = 1'b0;
    dwdata        = alu_res;
    ram_we        = 1'b0;
    ram_waddr     = didx_r;
    ram_wdata     = alu_res;
    alu_req.start = 1'b0;
    alu_req.op    = alu_op_t'(op_r);
    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
      end
      S_DEC: begin
        val_nxt = '0;
        st_nxt  = ST_OK;
        wm_nxt  = 1'b0;
        case (req_r)
          REQ_ARITH: begin
            if (codes_ok) begin
              if (dst_d) a_nxt = dreg_rd;
              else if (!addr_ok) st_nxt = ST_ADDR;
              else didx_nxt = chk_idx;
            end
          end
          REQ_WR_D: begin
            if (dst_d) begin
              dwe     = 1'b1;
              dwdata  = imm_r;
              val_nxt = imm_r;
            end
          end
          REQ_WR_A: begin
            if (dst_a) begin
              awe     = 1'b1;
              val_nxt = addr_r;
            end
          end
          REQ_WR_M: begin
            if (addr_ok) begin
              ram_we    = 1'b1;
              ram_waddr = chk_idx;
              ram_wdata = imm_r;
              val_nxt   = imm_r;
              wm_nxt    = 1'b1;
            end else begin
              st_nxt = ST_ADDR;
            end
          end
          REQ_READ: begin
            if (dst_d) val_nxt = dreg_rd;
            else if (dst_a) val_nxt = areg_rd;
            else if (!addr_ok) st_nxt = ST_ADDR;
          end
          default: ;
        endcase
      end
      S_DRD: a_nxt = ram_rdata;
      S_SRC: begin
        if (src_0) b_nxt = imm_r;
        else if (src_d) b_nxt = dreg_rd;
        else if (!addr_ok) st_nxt = ST_ADDR;
      end
      S_SRD:  b_nxt = ram_rdata;
      S_EXEC: alu_req.start = 1'b1;
      S_WAIT: begin
        if (alu_rsp.done) begin
          if (alu_rsp.div0) begin
            st_nxt  = ST_DIV0;
            val_nxt = '0;
          end else begin
            val_nxt = alu_res;
            if (dst_d) begin
              dwe = 1'b1;
            end else begin
              ram_we = 1'b1;
              wm_nxt = 1'b1;
            end
          end
        end
      end
      S_RRD: val_nxt = ram_rdata;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_r <= clr_r + IDX_W'(1);
    end
  end

  // register files
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NREGS; i++) begin
        dreg_r[i] <= '0;
        areg_r[i] <= '0;
      end
    end else begin
      if (dwe) dreg_r[ridx] <= dwdata;
      if (awe) areg_r[ridx] <= addr_r;
    end
  end

  // item capture and payload
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r  <= in_req_type;
      core_r <= in_core;
      dst_r  <= in_dest_reg;
      src_r  <= in_src_reg;
      imm_r  <= in_immediate;
      op_r   <= in_alu_op;
      addr_r <= in_addr_value;
    end
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    didx_r <= didx_nxt;
    val_r  <= val_nxt;
    st_r   <= st_nxt;
    wm_r   <= wm_nxt;
  end

  dcae_ram #(
    .WIDTH (16),
    .DEPTH (DATA_WORDS)
  ) u_mem (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (chk_idx),
    .rdata (ram_rdata)
  );

  dcae_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (alu_req),
    .a      (a_r),
    .b      (b_r),
    .rsp    (alu_rsp),
    .result (alu_res)
  );

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = (state_r == S_OUT);
  assign out_result_value = val_r;
  assign out_status       = st_r;
  assign out_wrote_memory = wm_r;

endmodule

@@ design/dcae_checker.sv @@
// ----------------------------------------------------------------------------
// dcae_checker
// Port-level checks for the execute unit, bound to the top level.
// ----------------------------------------------------------------------------
module dcae_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [1:0] out_status,
  input logic       out_wrote_memory
);
  import dcae_pkg::*;

  // a result is only shown while an item is in flight
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe while idle");

  // each item yields a single one-cycle strobe
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // a flagged item never writes memory
  a_err_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> !out_wrote_memory)
    else $error("memory written on a flagged item");

  // an accepted item holds the unit busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("unit not busy after accepting an item");

endmodule

bind dual_core_arith_execute_unit dcae_checker u_dcae_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_status       (out_status),
  .out_wrote_memory (out_wrote_memory)
);
